### rtl/core/ach_pkg.sv
package ach_pkg;

    // Sample and level widths fixed by the word format
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = SAMPLE_W - 1;
    localparam int LEVEL_W  = 8;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 8'd0;

    // Word kinds
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH_WR,
        ST_SCAN,
        ST_SCAN_END,
        ST_RD_MOD,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_RD_DIV,
        ST_DONE
    } state_t;

endpackage

### rtl/core/ach_ram.sv
module ach_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/ach_div.sv
module ach_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ach_pkg::MAG_W-1:0]   num,
    input  logic [ach_pkg::MAG_W-1:0]   den,
    output logic [ach_pkg::LEVEL_W-1:0] quot,
    output logic                        done
);

    // Restoring division of num * 255 by den, one quotient bit a cycle.
    // Valid only for 0 < num < den, where the quotient fits in a byte.
    localparam int NW = ach_pkg::MAG_W + ach_pkg::LEVEL_W;

    logic [NW-1:0]                  prod;
    logic [ach_pkg::MAG_W-1:0]      rem_reg;
    logic [ach_pkg::LEVEL_W-1:0]    bits_reg;
    logic [ach_pkg::LEVEL_W-1:0]    quot_reg;
    logic [ach_pkg::MAG_W-1:0]      den_reg;
    logic [2:0]                     cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [ach_pkg::MAG_W:0]        trial;
    logic [ach_pkg::MAG_W:0]        diff;
    logic                           take;

    // num * 255 as (num << 8) - num
    assign prod = {num, ach_pkg::LEVEL_W'(0)} - {ach_pkg::LEVEL_W'(0), num};

    // One restoring step
    assign trial = {rem_reg, bits_reg[ach_pkg::LEVEL_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign take  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder, remaining dividend bits, quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= prod[NW-1:ach_pkg::LEVEL_W];
            bits_reg <= prod[ach_pkg::LEVEL_W-1:0];
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= take ? diff[ach_pkg::MAG_W-1:0] : trial[ach_pkg::MAG_W-1:0];
            bits_reg <= {bits_reg[ach_pkg::LEVEL_W-2:0], 1'b0};
            quot_reg <= {quot_reg[ach_pkg::LEVEL_W-2:0], take};
        end
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

### rtl/core/autoscaled_two_channel_history_top.sv
// Push word: written, then one scan read per entry through the dual history RAMs,
//   then peak update and output load.
// Read word: ring index wrap in DEPTH steps, address, data read, the byte divider
//   and output load. One word in flight at a time.
// Reset: asynchronous, active low; ring position, fill count and peak clear.
//   Entries beyond the fill count read as zero, so no clearing pass is needed.
module autoscaled_two_channel_history_top #(
    parameter int DEPTH = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        kind,
    input  logic signed [15:0]          sample_a,
    input  logic signed [15:0]          sample_b,
    input  logic signed [15:0]          floor_ref,
    input  logic [5:0]                  pixel_pos,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  level_a,
    output logic [7:0]                  level_b,
    output logic signed [15:0]          peak
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int SW = ((AW > 6) ? AW : 6) + 1;
    localparam int SAMPLE_W = ach_pkg::SAMPLE_W;
    localparam int MAG_W    = ach_pkg::MAG_W;
    localparam int LEVEL_W  = ach_pkg::LEVEL_W;

    ach_pkg::state_t state_reg, state_next;

    logic [AW-1:0]          wp_reg;
    logic [FW-1:0]          fill_reg;
    logic [AW-1:0]          cnt_reg;
    logic                   pend_reg;
    logic [AW-1:0]          pend_addr_reg;
    logic [SW-1:0]          sum_reg;
    ach_pkg::sample_t       peak_reg;
    ach_pkg::sample_t       best_reg;
    ach_pkg::sample_t       sa_reg;
    ach_pkg::sample_t       sb_reg;
    logic [LEVEL_W-1:0]     res_a_reg;
    logic [LEVEL_W-1:0]     res_b_reg;
    logic                   out_valid_reg;
    logic [LEVEL_W-1:0]     level_a_reg;
    logic [LEVEL_W-1:0]     level_b_reg;
    ach_pkg::sample_t       peak_out_reg;

    logic                   in_acc;
    logic                   ram_we;
    logic [AW-1:0]          ram_raddr;
    logic [SAMPLE_W-1:0]    rdata_a;
    logic [SAMPLE_W-1:0]    rdata_b;
    logic                   div_start;
    logic [LEVEL_W-1:0]     quot_a;
    logic [LEVEL_W-1:0]     quot_b;
    logic                   done_a;
    logic                   done_b;
    logic                   load_out;
    logic [AW-1:0]          wp_inc;
    logic                   scan_hit;
    logic                   rd_hit;
    ach_pkg::sample_t       cand_a;
    ach_pkg::sample_t       cand_b;
    ach_pkg::sample_t       best_1;
    ach_pkg::sample_t       best_upd;
    ach_pkg::sample_t       rd_a;
    ach_pkg::sample_t       rd_b;
    logic                   peak_pos;
    logic [LEVEL_W-1:0]     lvl_a;
    logic [LEVEL_W-1:0]     lvl_b;

    assign in_acc = in_valid && in_ready;

    // History stores, one per channel
    ach_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram_a (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (sa_reg),
        .raddr (ram_raddr),
        .rdata (rdata_a)
    );

    ach_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram_b (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (sb_reg),
        .raddr (ram_raddr),
        .rdata (rdata_b)
    );

    // Entries at or above the fill count were never written: they read as zero
    assign scan_hit = (FW'(pend_addr_reg) < fill_reg);
    assign rd_hit   = (FW'(sum_reg[AW-1:0]) < fill_reg);

    assign rd_a = rd_hit ? $signed(rdata_a) : '0;
    assign rd_b = rd_hit ? $signed(rdata_b) : '0;

    // Byte dividers, one per channel
    ach_div u_div_a (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (rd_a[MAG_W-1:0]),
        .den   (peak_reg[MAG_W-1:0]),
        .quot  (quot_a),
        .done  (done_a)
    );

    ach_div u_div_b (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (rd_b[MAG_W-1:0]),
        .den   (peak_reg[MAG_W-1:0]),
        .quot  (quot_b),
        .done  (done_b)
    );

    // Running maximum over the scanned pair
    always_comb
    begin
        cand_a   = scan_hit ? $signed(rdata_a) : '0;
        cand_b   = scan_hit ? $signed(rdata_b) : '0;
        best_1   = (cand_a > best_reg) ? cand_a : best_reg;
        best_upd = (cand_b > best_1) ? cand_b : best_1;
    end

    // Intensity bytes: zero for a non-positive peak or sample, full at or above
    assign peak_pos = !peak_reg[SAMPLE_W-1] && (peak_reg != '0);

    always_comb
    begin
        priority if (!peak_pos || sa_reg[SAMPLE_W-1] || (sa_reg == '0))
        begin
            lvl_a = ach_pkg::LEVEL_ZERO;
        end
        else if (sa_reg >= peak_reg)
        begin
            lvl_a = ach_pkg::LEVEL_MAX;
        end
        else
        begin
            lvl_a = quot_a;
        end

        priority if (!peak_pos || sb_reg[SAMPLE_W-1] || (sb_reg == '0))
        begin
            lvl_b = ach_pkg::LEVEL_ZERO;
        end
        else if (sb_reg >= peak_reg)
        begin
            lvl_b = ach_pkg::LEVEL_MAX;
        end
        else
        begin
            lvl_b = quot_b;
        end
    end

    assign wp_inc   = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign load_out = (state_reg == ach_pkg::ST_DONE) && (!out_valid_reg || out_ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ach_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (kind == ach_pkg::KIND_READ) ? ach_pkg::ST_RD_MOD
                                                               : ach_pkg::ST_PUSH_WR;
                end
            end
            ach_pkg::ST_PUSH_WR:
            begin
                state_next = ach_pkg::ST_SCAN;
            end
            ach_pkg::ST_SCAN:
            begin
                if (cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ach_pkg::ST_SCAN_END;
                end
            end
            ach_pkg::ST_SCAN_END:
            begin
                state_next = ach_pkg::ST_DONE;
            end
            ach_pkg::ST_RD_MOD:
            begin
                if (sum_reg < SW'(DEPTH))
                begin
                    state_next = ach_pkg::ST_RD_ADDR;
                end
            end
            ach_pkg::ST_RD_ADDR:
            begin
                state_next = ach_pkg::ST_RD_DATA;
            end
            ach_pkg::ST_RD_DATA:
            begin
                state_next = ach_pkg::ST_RD_DIV;
            end
            ach_pkg::ST_RD_DIV:
            begin
                if (done_a && done_b)
                begin
                    state_next = ach_pkg::ST_DONE;
                end
            end
            ach_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ach_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ach_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = cnt_reg;
        div_start = 1'b0;
        unique case (state_reg)
            ach_pkg::ST_IDLE:     in_ready  = 1'b1;
            ach_pkg::ST_PUSH_WR:  ram_we    = 1'b1;
            ach_pkg::ST_RD_ADDR:  ram_raddr = sum_reg[AW-1:0];
            ach_pkg::ST_RD_DATA:  div_start = 1'b1;
            default:
            begin
                ram_raddr = cnt_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ach_pkg::ST_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            peak_reg      <= '0;
            pend_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == ach_pkg::ST_SCAN);

            if (state_reg == ach_pkg::ST_PUSH_WR)
            begin
                wp_reg  <= wp_inc;
                cnt_reg <= '0;
                if (fill_reg != FW'(DEPTH))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            else if (state_reg == ach_pkg::ST_SCAN)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (state_reg == ach_pkg::ST_SCAN_END)
            begin
                peak_reg <= best_upd;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            sa_reg   <= sample_a;
            sb_reg   <= sample_b;
            best_reg <= floor_ref;
            sum_reg  <= SW'(wp_reg) + SW'(pixel_pos);
        end
        else if (pend_reg)
        begin
            best_reg <= best_upd;
        end

        if (state_reg == ach_pkg::ST_SCAN)
        begin
            pend_addr_reg <= cnt_reg;
        end

        // Ring index wrap, one DEPTH step a cycle
        if ((state_reg == ach_pkg::ST_RD_MOD) && (sum_reg >= SW'(DEPTH)))
        begin
            sum_reg <= sum_reg - SW'(DEPTH);
        end

        if (state_reg == ach_pkg::ST_RD_DATA)
        begin
            sa_reg <= rd_a;
            sb_reg <= rd_b;
        end

        if (state_reg == ach_pkg::ST_SCAN_END)
        begin
            res_a_reg <= ach_pkg::LEVEL_ZERO;
            res_b_reg <= ach_pkg::LEVEL_ZERO;
        end
        else if ((state_reg == ach_pkg::ST_RD_DIV) && done_a && done_b)
        begin
            res_a_reg <= lvl_a;
            res_b_reg <= lvl_b;
        end

        if (load_out)
        begin
            level_a_reg  <= res_a_reg;
            level_b_reg  <= res_b_reg;
            peak_out_reg <= peak_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign level_a   = level_a_reg;
    assign level_b   = level_b_reg;
    assign peak      = peak_out_reg;

`ifndef SYNTHESIS
    // Until the ring has wrapped, the write position equals the fill count
    a_fill_tracks_wp: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != FW'(DEPTH)) |-> (FW'(wp_reg) == fill_reg))
        else $error("write position and fill count disagree");

    // Fill count never passes the ring depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(DEPTH))
        else $error("fill count beyond depth");

    // Dividers finish only while the sequencer waits for them
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (done_a || done_b) |-> (state_reg == ach_pkg::ST_RD_DIV))
        else $error("divider finished outside read");

    // A non-positive peak always goes out with zero levels
    a_zero_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (peak_out_reg[SAMPLE_W-1] || (peak_out_reg == '0)))
        |-> ((level_a == ach_pkg::LEVEL_ZERO) && (level_b == ach_pkg::LEVEL_ZERO)))
        else $error("non-zero level with non-positive peak");
`endif

endmodule

### dv/tb_autoscaled_two_channel_history_top.sv
`timescale 1ns / 100ps

module tb_autoscaled_two_channel_history_top;

    localparam int RING_DEPTH    = 64;
    localparam int RANDOM_WORDS  = 1400;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_CYCLES  = 100;
    localparam int HOLD_CYCLES   = 500;
    localparam int IDLE_PCT      = 26;
    localparam int MAX_REPORTS   = 10;
    localparam int DIR_ROWS      = 16;

    // Random run styles
    localparam int STYLE_MIXED = 0;
    localparam int STYLE_NEG   = 1;
    localparam int STYLE_SMALL = 2;
    localparam int STYLE_FLOOR = 3;

    typedef struct {
        logic [7:0]       level_a;
        logic [7:0]       level_b;
        ach_pkg::sample_t peak;
    } pixel_result_t;

    typedef struct {
        logic             kind;
        ach_pkg::sample_t sample_a;
        ach_pkg::sample_t sample_b;
        ach_pkg::sample_t floor_ref;
        logic [5:0]       pixel_pos;
        bit               typed;
        pixel_result_t    want;
    } stim_word_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic             kind;
    ach_pkg::sample_t sample_a;
    ach_pkg::sample_t sample_b;
    ach_pkg::sample_t floor_ref;
    logic [5:0]       pixel_pos;
    logic             out_valid;
    logic             out_ready;
    logic [7:0]       level_a;
    logic [7:0]       level_b;
    ach_pkg::sample_t peak;

    // Shared between sender, receiver and checker
    bit            quiet;
    bit            stall_go;
    bit            row_typed;
    pixel_result_t row_want;
    int            fail_count;
    int            cycle_count;

    // Predicted history state
    ach_pkg::sample_t ring_a [RING_DEPTH];
    ach_pkg::sample_t ring_b [RING_DEPTH];
    logic [5:0]       ring_wr;
    ach_pkg::sample_t ring_peak;
    pixel_result_t    pending_results [$];

    stim_word_t    directed_words [DIR_ROWS];

    autoscaled_two_channel_history_top #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .sample_a  (sample_a),
        .sample_b  (sample_b),
        .floor_ref (floor_ref),
        .pixel_pos (pixel_pos),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .level_a   (level_a),
        .level_b   (level_b),
        .peak      (peak)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("autoscaled_two_channel_history_top verification failed");
            $finish;
        end
    end

    // Intensity byte: sample scaled against the peak, clamped, truncated
    function automatic logic [7:0] scaled_level(input ach_pkg::sample_t s,
                                                input ach_pkg::sample_t pk);
        if (pk <= 0 || s <= 0)
            return 8'd0;
        if (s >= pk)
            return ach_pkg::LEVEL_MAX;
        return 8'((int'(s) * 255) / int'(pk));
    endfunction

    function automatic ach_pkg::sample_t pick_sample(input int style);
        case (style)
            STYLE_NEG:   return ach_pkg::sample_t'(-1 - int'($urandom_range(32767)));
            STYLE_SMALL: return ach_pkg::sample_t'($urandom_range(300));
            default:     return ach_pkg::sample_t'($urandom_range(65535));
        endcase
    endfunction

    function automatic ach_pkg::sample_t pick_floor(input int style);
        case (style)
            STYLE_NEG:   return ach_pkg::sample_t'(-1 - int'($urandom_range(32767)));
            STYLE_SMALL: return ach_pkg::sample_t'(int'($urandom_range(350)) - 50);
            STYLE_FLOOR: return ach_pkg::sample_t'($urandom_range(32767, 1000));
            default:     return ach_pkg::sample_t'($urandom_range(65535));
        endcase
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] %s", $time, what);
    endtask

    // Offer one word: random gap, then hold it until accepted
    task automatic send_word(input stim_word_t w);
        @(negedge clk);
        if (!quiet)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        end
        kind      = w.kind;
        sample_a  = w.sample_a;
        sample_b  = w.sample_b;
        floor_ref = w.floor_ref;
        pixel_pos = w.pixel_pos;
        row_typed = w.typed;
        row_want  = w.want;
        in_valid  = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Output side: random back-pressure, one long hold-off, quiet stretch
    initial
    begin
        int held;
        held = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_go && held < HOLD_CYCLES)
            begin
                out_ready = 1'b0;
                held++;
            end
            else if (quiet)
                out_ready = 1'b1;
            else
                out_ready = ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Check results leaving, predict words entering
    always @(posedge clk)
    begin : result_check
        pixel_result_t got;
        pixel_result_t want;
        pixel_result_t model;
        int            best;
        logic [5:0]    idx;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{level_a, level_b, peak};
            if (pending_results.size() == 0)
                note_failure($sformatf("unexpected result a=%0d b=%0d peak=%0d",
                                       got.level_a, got.level_b, got.peak));
            else
            begin
                want = pending_results.pop_front();
                if (got.level_a !== want.level_a || got.level_b !== want.level_b ||
                    got.peak !== want.peak)
                    note_failure($sformatf(
                        "mismatch: expected a=%0d b=%0d peak=%0d, got a=%0d b=%0d peak=%0d",
                        want.level_a, want.level_b, want.peak,
                        got.level_a, got.level_b, got.peak));
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            if (kind == ach_pkg::KIND_PUSH)
            begin
                ring_a[ring_wr] = sample_a;
                ring_b[ring_wr] = sample_b;
                ring_wr = ring_wr + 6'd1;
                best = int'(floor_ref);
                // full rescan, unwritten entries count as zero
                for (int i = 0; i < RING_DEPTH; i++)
                begin
                    if (int'(ring_a[i]) > best)
                        best = int'(ring_a[i]);
                    if (int'(ring_b[i]) > best)
                        best = int'(ring_b[i]);
                end
                ring_peak = ach_pkg::sample_t'(best);
                model = '{ach_pkg::LEVEL_ZERO, ach_pkg::LEVEL_ZERO, ring_peak};
            end
            else
            begin
                // display position counts from the oldest entry, wraps round the ring
                idx = ring_wr + pixel_pos;
                model = '{scaled_level(ring_a[idx], ring_peak),
                          scaled_level(ring_b[idx], ring_peak), ring_peak};
            end
            pending_results.push_back(row_typed ? row_want : model);
        end
    end

    initial
    begin
        int         sent;
        int         style;
        int         run_len;
        int         push_pct;
        stim_word_t w;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = ach_pkg::KIND_PUSH;
        sample_a    = '0;
        sample_b    = '0;
        floor_ref   = '0;
        pixel_pos   = '0;
        quiet       = 1'b0;
        stall_go    = 1'b0;
        row_typed   = 1'b0;
        row_want    = '{ach_pkg::LEVEL_ZERO, ach_pkg::LEVEL_ZERO, 16'sd0};
        fail_count  = 0;
        cycle_count = 0;
        ring_wr     = '0;
        ring_peak   = '0;
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            ring_a[i] = '0;
            ring_b[i] = '0;
        end

        // kind, a, b, floor, pos, typed, expected {level_a, level_b, peak}
        directed_words = '{
            // empty ring, zero peak
            '{ach_pkg::KIND_READ, 16'sd0, 16'sd0, 16'sd0, 6'd0, 1'b1,
              '{8'd0, 8'd0, 16'sd0}},
            // lowest floor, peak stays at zero from the cleared entries
            '{ach_pkg::KIND_PUSH, 16'sd0, 16'sd0, 16'sh8000, 6'd0, 1'b1,
              '{8'd0, 8'd0, 16'sd0}},
            '{ach_pkg::KIND_READ, 16'sd0, 16'sd0, 16'sd0, 6'd63, 1'b1,
              '{8'd0, 8'd0, 16'sd0}},
            // extremes of both channels
            '{ach_pkg::KIND_PUSH, 16'sd32767, 16'sh8000, 16'sd0, 6'd0, 1'b1,
              '{8'd0, 8'd0, 16'sd32767}},
            '{ach_pkg::KIND_READ, 16'sd0, 16'sd0, 16'sd0, 6'd63, 1'b1,
              '{8'd255, 8'd0, 16'sd32767}},
            '{ach_pkg::KIND_READ, 16'sd0, 16'sd0, 16'sd0, 6'd62, 1'b1,
              '{8'd0, 8'd0, 16'sd32767}},
            '{ach_pkg::KIND_PUSH, -16'sd1, 16'sd16384, 16'sd32767, 6'd0, 1'b1,
              '{8'd0, 8'd0, 16'sd32767}},
            '{ach_pkg::KIND_READ, 16'sd0, 16'sd0, 16'sd0, 6'd63, 1'b0,
              '{8'd0, 8'd0, 16'sd0}},
            '{ach_pkg::KIND_PUSH, 16'sd100, 16'sd200, 16'sh8000, 6'd0, 1'b0,
              '{8'd0, 8'd0, 16'sd0}},
            // unwritten entry
            '{ach_pkg::KIND_READ, 16'sd0, 16'sd0, 16'sd0, 6'd0, 1'b0,
              '{8'd0, 8'd0, 16'sd0}},
            '{ach_pkg::KIND_PUSH, 16'sd32767, 16'sd32767, -16'sd1, 6'd0, 1'b1,
              '{8'd0, 8'd0, 16'sd32767}},
            '{ach_pkg::KIND_READ, 16'sd0, 16'sd0, 16'sd0, 6'd61, 1'b0,
              '{8'd0, 8'd0, 16'sd0}},
            // sample equal to peak
            '{ach_pkg::KIND_READ, 16'sd0, 16'sd0, 16'sd0, 6'd63, 1'b1,
              '{8'd255, 8'd255, 16'sd32767}},
            '{ach_pkg::KIND_PUSH, 16'sd1, -16'sd32767, 16'sh8000, 6'd0, 1'b0,
              '{8'd0, 8'd0, 16'sd0}},
            '{ach_pkg::KIND_READ, 16'sd0, 16'sd0, 16'sd0, 6'd63, 1'b0,
              '{8'd0, 8'd0, 16'sd0}},
            '{ach_pkg::KIND_READ, 16'sd0, 16'sd0, 16'sd0, 6'd31, 1'b0,
              '{8'd0, 8'd0, 16'sd0}}
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_words[i])
            send_word(directed_words[i]);

        // Random runs; the negative style flushes the ring to drive the peak below zero
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            style = $urandom_range(3);
            if (style == STYLE_NEG)
            begin
                run_len  = $urandom_range(110, 90);
                push_pct = 85;
            end
            else
            begin
                run_len  = $urandom_range(80, 20);
                push_pct = (style == STYLE_SMALL) ? 60 : 50;
            end
            for (int i = 0; i < run_len && sent < RANDOM_WORDS; i++)
            begin
                quiet = (sent >= 500 && sent < 760);
                if (sent == 250)
                    stall_go = 1'b1;
                w.kind      = ($urandom_range(99) < push_pct) ? ach_pkg::KIND_PUSH
                                                              : ach_pkg::KIND_READ;
                w.sample_a  = pick_sample(style);
                w.sample_b  = pick_sample(style);
                w.floor_ref = pick_floor(style);
                w.pixel_pos = 6'($urandom_range(63));
                w.typed     = 1'b0;
                w.want      = '{ach_pkg::LEVEL_ZERO, ach_pkg::LEVEL_ZERO, 16'sd0};
                send_word(w);
                sent++;
            end
        end

        @(negedge clk);
        in_valid = 1'b0;
        quiet = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_results.size() == 0)
            $display("autoscaled_two_channel_history_top verification clean");
        else
            $display("autoscaled_two_channel_history_top verification failed");
        $finish;
    end

endmodule
